[hdl/scw_pkg.sv]
// Package for the skipping CRC-16 word scan: config and result types,
// register index codes, fold constants and the fold function. No dependencies.
package scw_pkg;

   localparam int CHECK_WIDTH     = 32;
   localparam int MASK_WIDTH      = 8;
   localparam int CFG_INDEX_WIDTH = 24;
   localparam int WINDOW_WIDTH    = 24;
   localparam int DATA_WIDTH      = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int FOLD_SHIFTS     = 8;

   localparam logic [CHECK_WIDTH-1:0] POLY    = 32'h0000_8005;
   localparam int                     TOP_BIT = 15;

   typedef enum logic [1:0] {
      REG_INITIAL_CHECK = 2'd0,
      REG_SKIP_MASK     = 2'd1,
      REG_SCAN_START    = 2'd2,
      REG_SCAN_END      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CHECK_WIDTH-1:0]     initial_check;
      logic [MASK_WIDTH-1:0]      skip_mask;
      logic [CFG_INDEX_WIDTH-1:0] scan_start;
      logic [CFG_INDEX_WIDTH-1:0] scan_end;
   } cfg_type;

   typedef struct packed {
      logic [CHECK_WIDTH-1:0] check_value;
      logic                   step_taken;
      logic                   scan_done;
   } result_type;

   // xor word<<8 into the check, then eight shift steps with poly 0x8005 on bit 15
   function automatic logic [CHECK_WIDTH-1:0] fold_word(
      input logic [CHECK_WIDTH-1:0] chk,
      input logic [CHECK_WIDTH-1:0] word
   );
      logic [CHECK_WIDTH-1:0] c;
      c = chk ^ {word[CHECK_WIDTH-9:0], 8'h00};
      for (int k = 0; k < FOLD_SHIFTS; k++) begin
         if (c[TOP_BIT]) begin
            c = {c[CHECK_WIDTH-2:0], 1'b0} ^ POLY;
         end else begin
            c = {c[CHECK_WIDTH-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hdl/scw_csr.sv]
// Configuration register file of the word scan, APB-style access.
// Depends on scw_pkg for the register codes and the config struct.
module scw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [scw_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [scw_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [scw_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output scw_pkg::cfg_type                    cfg
);
   import scw_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_INITIAL_CHECK: cfg_in.initial_check = pwdata;
            REG_SKIP_MASK:     cfg_in.skip_mask     = pwdata[MASK_WIDTH-1:0];
            REG_SCAN_START:    cfg_in.scan_start    = pwdata[CFG_INDEX_WIDTH-1:0];
            REG_SCAN_END:      cfg_in.scan_end      = pwdata[CFG_INDEX_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_INITIAL_CHECK: prdata = cfg_ff.initial_check;
         REG_SKIP_MASK:     prdata = CSR_DATA_WIDTH'(cfg_ff.skip_mask);
         REG_SCAN_START:    prdata = CSR_DATA_WIDTH'(cfg_ff.scan_start);
         REG_SCAN_END:      prdata = CSR_DATA_WIDTH'(cfg_ff.scan_end);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/skipping_crc16_word_scan_top.sv]
// Skipping CRC-16 word scan, top level: scan state, fold step, output skid.
// The result is registered in the output register, or in the skid while the output is stalled.
// One byte item per cycle while req_stall is low; the fold is one 8-step xor network.
// A two-entry output (register plus skid) keeps input flowing after a stall until the skid fills.
// Synchronous active-high reset clears scan state, config and output valids.
// Depends on scw_pkg and scw_csr.
module skipping_crc16_word_scan_top #(
   parameter int INDEX_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [scw_pkg::DATA_WIDTH-1:0]      req_data_byte,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [scw_pkg::CHECK_WIDTH-1:0]     rsp_check_value,
   output logic                                rsp_step_taken,
   output logic                                rsp_scan_done,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [scw_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [scw_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [scw_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   import scw_pkg::*;

   localparam int NW = INDEX_WIDTH + 1;
   localparam int SW = INDEX_WIDTH + 2;
   localparam int CW = (NW > CFG_INDEX_WIDTH) ? NW : CFG_INDEX_WIDTH;
   localparam logic [CW-1:0] NEXT_MAX_W = CW'({NW{1'b1}});

   cfg_type cfg;

   logic [CHECK_WIDTH-1:0]  running_check_ff, running_check_in;
   logic [INDEX_WIDTH-1:0]  byte_index_ff, byte_index_in;
   logic [NW-1:0]           next_word_ff, next_word_in;
   logic [WINDOW_WIDTH-1:0] window_ff, window_in;
   logic                    done_ff, done_in;

   result_type out_ff, out_in, skid_ff, skid_in, res;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                    accept, out_take, fire;
   logic [CHECK_WIDTH-1:0]  chk0, chk1;
   logic [NW-1:0]           next0, next1;
   logic [WINDOW_WIDTH-1:0] win0;
   logic [INDEX_WIDTH-1:0]  idx;
   logic                    done0;
   logic [CW-1:0]           start_w;
   logic [SW-1:0]           next_sum;

   scw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   // fold step
   always_comb begin
      start_w = CW'(cfg.scan_start);
      if (req_frame_start) begin
         chk0  = cfg.initial_check;
         next0 = (start_w > NEXT_MAX_W) ? {NW{1'b1}} : start_w[NW-1:0];
         win0  = '0;
         idx   = '0;
         done0 = 1'b0;
      end else begin
         chk0  = running_check_ff;
         next0 = next_word_ff;
         win0  = window_ff;
         idx   = byte_index_ff;
         done0 = done_ff;
      end

      fire = !done0 && (CW'(next0) < CW'(cfg.scan_end))
             && (SW'(idx) == SW'(next0) + SW'(3));

      chk1 = fire ? fold_word(chk0, {req_data_byte, win0}) : chk0;

      next_sum = SW'(next0) + SW'(chk1[MASK_WIDTH-1:0] & cfg.skip_mask) + SW'(1);
      if (!fire) begin
         next1 = next0;
      end else if (next_sum[SW-1]) begin
         next1 = {NW{1'b1}};
      end else begin
         next1 = next_sum[NW-1:0];
      end

      done_in          = done0 || (CW'(next1) >= CW'(cfg.scan_end));
      running_check_in = chk1;
      next_word_in     = next1;
      window_in        = {req_data_byte, win0[WINDOW_WIDTH-1:DATA_WIDTH]};
      byte_index_in    = (&idx) ? idx : idx + INDEX_WIDTH'(1);

      res.check_value = chk1;
      res.step_taken  = fire;
      res.scan_done   = done_in;
   end

   // output register with skid
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (accept) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_check_ff <= '0;
         byte_index_ff    <= '0;
         next_word_ff     <= '0;
         window_ff        <= '0;
         done_ff          <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            running_check_ff <= running_check_in;
            byte_index_ff    <= byte_index_in;
            next_word_ff     <= next_word_in;
            window_ff        <= window_in;
            done_ff          <= done_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_check_value = out_ff.check_value;
   assign rsp_step_taken  = out_ff.step_taken;
   assign rsp_scan_done   = out_ff.scan_done;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while output register is empty");

   a_no_fold_when_done: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_frame_start && done_ff) |-> !fire)
      else $error("fold fired after scan finished");

   a_check_frozen: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_frame_start && done_ff) |=> $stable(running_check_ff))
      else $error("check changed after scan finished");

   a_frame_index: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_start) |=> (byte_index_ff == INDEX_WIDTH'(1)))
      else $error("byte index not restarted by frame start");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for skipping_crc16_word_scan_top: byte frames in, one check result per byte out.
// A scoreboard class predicts each result; plain tasks drive the stream and the APB port.
// Depends on scw_pkg and the block's RTL.
module tb_top;
   import scw_pkg::*;

   localparam logic [31:0]     CRC_POLY     = 32'h0000_8005;
   localparam longint unsigned NEXT_MAX     = (64'd1 << 25) - 1;
   localparam int              RUN_LIMIT    = 400000;
   localparam int              DIRECTED_CNT = 25;
   localparam int              RANDOM_ITEMS = 1425;

   class scan_scoreboard;
      logic [31:0] init_chk;
      logic [7:0]  mask;
      logic [23:0] start_idx;
      logic [23:0] end_idx;
      logic [31:0] chk;
      logic [23:0] byte_idx;
      logic [24:0] next_idx;
      logic [23:0] window;
      logic        done;
      result_type  expected_q[$];
      int          errors;
      int          inputs;
      int          results;
      int          folds;
      int          done_results;
      int          frames;

      function new();
         init_chk  = '0;
         mask      = '0;
         start_idx = '0;
         end_idx   = '0;
         chk       = '0;
         byte_idx  = '0;
         next_idx  = '0;
         window    = '0;
         done      = 1'b0;
      endfunction

      function void set_reg(reg_index_type r, logic [31:0] v);
         case (r)
            REG_INITIAL_CHECK: init_chk  = v;
            REG_SKIP_MASK:     mask      = v[7:0];
            REG_SCAN_START:    start_idx = v[23:0];
            REG_SCAN_END:      end_idx   = v[23:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(reg_index_type r);
         case (r)
            REG_INITIAL_CHECK: return init_chk;
            REG_SKIP_MASK:     return {24'd0, mask};
            REG_SCAN_START:    return {8'd0, start_idx};
            default:           return {8'd0, end_idx};
         endcase
      endfunction

      function logic [31:0] crc_fold(logic [31:0] c, logic [31:0] w);
         logic [31:0] r;
         logic        top;
         r = c ^ (w << 8);
         for (int k = 0; k < 8; k++) begin
            top = r[15];
            r   = r << 1;
            if (top) r ^= CRC_POLY;
         end
         return r;
      endfunction

      function void note_byte(logic [7:0] b, logic fs);
         longint unsigned nxt;
         result_type      r;
         logic            step;
         step = 1'b0;
         inputs++;
         if (fs) begin
            chk      = init_chk;
            next_idx = {1'b0, start_idx};
            window   = '0;
            byte_idx = '0;
            done     = 1'b0;
            frames++;
         end
         if (!done && next_idx < end_idx && byte_idx == next_idx + 3) begin
            chk = crc_fold(chk, {b, window});
            nxt = longint'(next_idx) + longint'(chk[7:0] & mask) + 1;
            if (nxt > NEXT_MAX) nxt = NEXT_MAX;
            next_idx = nxt[24:0];
            step     = 1'b1;
         end
         if (next_idx >= end_idx) done = 1'b1;
         window = {b, window[23:8]};
         if (byte_idx != '1) byte_idx++;
         r.check_value = chk;
         r.step_taken  = step;
         r.scan_done   = done;
         expected_q.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result with no item pending: check_value %h", got.check_value);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         results++;
         if (want.step_taken) folds++;
         if (want.scan_done) done_results++;
         if (got.check_value !== want.check_value) begin
            $error("check_value expected %h got %h", want.check_value, got.check_value);
            errors++;
         end
         if (got.step_taken !== want.step_taken) begin
            $error("step_taken expected %b got %b", want.step_taken, got.step_taken);
            errors++;
         end
         if (got.scan_done !== want.scan_done) begin
            $error("scan_done expected %b got %b", want.scan_done, got.scan_done);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte   = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [31:0] rsp_check_value;
   logic        rsp_step_taken;
   logic        rsp_scan_done;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [3:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;
   logic [31:0] prdata;
   logic        pready;

   scan_scoreboard sb;
   int             src_idle_pct  = 0;
   int             sink_stall_pct = 0;
   int             cycles        = 0;
   int             settings      = 0;

   skipping_crc16_word_scan_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_check_value (rsp_check_value),
      .rsp_step_taken  (rsp_step_taken),
      .rsp_scan_done   (rsp_scan_done),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(result_type'{rsp_check_value, rsp_step_taken, rsp_scan_done});
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fs);
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, fs);
   endtask

   // kind 0: clean frame, 1: stray frame starts, 2: frame start bit random
   task automatic send_frame(input int len, input int kind);
      logic fs;
      for (int i = 0; i < len; i++) begin
         case (kind)
            0:       fs = (i == 0);
            1:       fs = (i == 0) || ($urandom_range(99) < 5);
            default: fs = ($urandom_range(99) < 30);
         endcase
         send_byte($urandom_range(255), fs);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type r, input logic [31:0] v);
      paddr   <= {r, 2'b00};
      pwdata  <= v;
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(r, v);
   endtask

   task automatic csr_readback(input reg_index_type r);
      logic [31:0] got;
      paddr   <= {r, 2'b00};
      pwrite  <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== sb.reg_value(r)) begin
         $error("register %s expected %h got %h", r.name(), sb.reg_value(r), got);
         sb.errors++;
      end
   endtask

   task automatic configure(input logic [31:0] ic, input logic [7:0] m,
                            input logic [23:0] s, input logic [23:0] e);
      wait_idle();
      csr_write(REG_INITIAL_CHECK, ic);
      csr_write(REG_SKIP_MASK, {24'd0, m});
      csr_write(REG_SCAN_START, {8'd0, s});
      csr_write(REG_SCAN_END, {8'd0, e});
      for (int i = 0; i < 4; i++) csr_readback(reg_index_type'(i));
      settings++;
   endtask

   initial begin
      logic [31:0] ic;
      logic [7:0]  m;
      logic [23:0] s;
      logic [23:0] e;
      int          phase;
      int          sel;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // bytes before any frame start run on reset state
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);

      configure(32'hFFFF_FFFF, 8'h00, 24'd0, 24'hFF_FFFF);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);

      configure(32'h0000_0000, 8'hFF, 24'd2, 24'd10);
      send_frame(10, 0);

      // start past end: done from the first byte
      configure(32'h1234_5678, 8'h0F, 24'hFF_FFFF, 24'd0);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b0);

      // done stays set when scan_end moves without a new frame
      configure(32'h1234_5678, 8'h0F, 24'd0, 24'hFF_FFFF);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h81, 1'b0);

      phase = 0;
      while (sb.inputs < DIRECTED_CNT + RANDOM_ITEMS) begin
         wait_idle();
         case (phase % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
            default: begin src_idle_pct = 14; sink_stall_pct = 14; end
         endcase
         case ($urandom_range(3))
            0:       ic = '0;
            1:       ic = '1;
            default: ic = $urandom();
         endcase
         case ($urandom_range(3))
            0:       m = 8'h00;
            1:       m = 8'hFF;
            default: m = $urandom_range(255);
         endcase
         s = $urandom_range(12);
         e = s + $urandom_range(70);
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
               0:       s = 24'hFF_FFFF;
               1:       e = 24'hFF_FFFF;
               default: e = 24'd0;
            endcase
         end
         configure(ic, m, s, e);
         repeat ($urandom_range(3, 6)) begin
            if (sb.inputs < DIRECTED_CNT + RANDOM_ITEMS) begin
               sel = $urandom_range(99);
               if (sel < 80) send_frame($urandom_range(4, 70), 0);
               else if (sel < 92) send_frame($urandom_range(4, 70), 1);
               else send_frame($urandom_range(4, 40), 2);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d frames over %0d register settings and %0d phases.",
               sb.inputs, sb.frames, settings, phase);
      $display("Checked %0d results: %0d with a word fold, %0d with the scan done.",
               sb.results, sb.folds, sb.done_results);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[sim.f]
hdl/scw_pkg.sv
hdl/scw_csr.sv
hdl/skipping_crc16_word_scan_top.sv
verif/tb_top.sv
